[design/pidsep_pkg.sv]
// Shared types, register indexes and reset values for the PID controller block.
`timescale 1ns / 1ps

package pidsep_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEPARATION_BAND = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WINDUP_BOUND    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_ENABLE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_UPPER     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_LOWER     = 3'd7;

  localparam logic signed [15:0] RST_GAIN_PROP       = 16'sd256;
  localparam logic signed [15:0] RST_GAIN_INTEG      = 16'sd0;
  localparam logic signed [15:0] RST_GAIN_DERIV      = 16'sd0;
  localparam logic [14:0]        RST_SEPARATION_BAND = 15'd32767;
  localparam logic [29:0]        RST_WINDUP_BOUND    = 30'd1000000;
  localparam logic               RST_LIMIT_ENABLE    = 1'b0;
  localparam logic signed [31:0] RST_LIMIT_UPPER     = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] RST_LIMIT_LOWER     = 32'sh8000_0000;

  localparam logic KIND_STEP  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  typedef struct packed {
    logic              kind;
    logic signed [15:0] error_in;
    logic signed [15:0] deriv_in;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] drive_out;
    logic               integ_used;
  } out_item_t;

  // Integrator result handed to the multiply stage
  typedef struct packed {
    logic               use_i;
    logic signed [31:0] acc;
  } integ_res_t;

endpackage

[design/pidsep_integ.sv]
// Integral accumulator with separation band and anti-windup.
`timescale 1ns / 1ps

module pidsep_integ import pidsep_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  in_item_t    item,
  input  logic [14:0] band,
  input  logic [29:0] bound,
  output integ_res_t  res
);

  logic signed [31:0] integ_acc;
  logic signed [31:0] integ_acc_next;

  logic signed [16:0] err_x;
  logic signed [16:0] band_p;
  logic signed [16:0] band_n;
  logic               in_band;
  logic signed [32:0] acc_x;
  logic signed [32:0] bound_p;
  logic signed [32:0] bound_n;
  logic               add_en;
  logic signed [32:0] sum_x;
  logic signed [31:0] sum_sat;

  always_comb begin
    err_x   = {item.error_in[15], item.error_in};
    band_p  = {2'b00, band};
    band_n  = -band_p;
    in_band = !(err_x > band_p || err_x < band_n);

    acc_x   = {integ_acc[31], integ_acc};
    bound_p = {3'b000, bound};
    bound_n = -bound_p;
    // past a bound only error of the opposite sign gets in
    if (acc_x > bound_p) begin
      add_en = item.error_in[15];
    end else if (acc_x < bound_n) begin
      add_en = !item.error_in[15] && (item.error_in != 16'sd0);
    end else begin
      add_en = 1'b1;
    end

    sum_x = acc_x + (add_en ? {{17{item.error_in[15]}}, item.error_in} : 33'sd0);
    if (sum_x[32] != sum_x[31]) begin
      sum_sat = sum_x[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      sum_sat = sum_x[31:0];
    end

    if (item.kind == KIND_CLEAR) begin
      integ_acc_next = 32'sd0;
    end else if (in_band) begin
      integ_acc_next = sum_sat;
    end else begin
      integ_acc_next = integ_acc;
    end

    res.use_i = (item.kind == KIND_STEP) && in_band;
    res.acc   = integ_acc_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integ_acc <= 32'sd0;
    end else if (take) begin
      integ_acc <= integ_acc_next;
    end
  end

endmodule

[design/pid_integral_separation_antiwindup.sv]
// Top level: positional PID step with integral separation, anti-windup and clamp.
`timescale 1ns / 1ps
//
// Input channel in_valid/in_ready/in_data carries one item: kind, error_in,
// deriv_in. kind selects a compute step or a clear of the integral.
// Output channel out_valid/out_ready/out_data returns one item per input:
// drive_out and integ_used.
// Registers are written through cfg_wr_en/cfg_index/cfg_data, one per cycle.
// The user must write them only while no item is in flight; the block itself
// does not enforce this. An accepted item is registered in stage 1, then in
// stage 2, then in the output register, from which its result is taken.
// One item per cycle while the receiver does not stall. The integral is
// updated as the item is taken, so the accumulator feedback loop holds a
// single register; the three gain multiplies sit in the next stage and the
// sum, shift, saturation and clamp in the output stage.
// Reset clears the integral and the pipeline and loads the register defaults.
// When the receiver stalls, the three stages hold and fill up; in_ready
// drops once all of them hold an item.

module pid_integral_separation_antiwindup import pidsep_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration
  logic signed [15:0] gain_prop;
  logic signed [15:0] gain_integ;
  logic signed [15:0] gain_deriv;
  logic [14:0]        separation_band;
  logic [29:0]        windup_bound;
  logic               limit_enable;
  logic signed [31:0] limit_upper;
  logic signed [31:0] limit_lower;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_prop       <= RST_GAIN_PROP;
      gain_integ      <= RST_GAIN_INTEG;
      gain_deriv      <= RST_GAIN_DERIV;
      separation_band <= RST_SEPARATION_BAND;
      windup_bound    <= RST_WINDUP_BOUND;
      limit_enable    <= RST_LIMIT_ENABLE;
      limit_upper     <= RST_LIMIT_UPPER;
      limit_lower     <= RST_LIMIT_LOWER;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_GAIN_PROP:       gain_prop       <= cfg_data[15:0];
        REG_GAIN_INTEG:      gain_integ      <= cfg_data[15:0];
        REG_GAIN_DERIV:      gain_deriv      <= cfg_data[15:0];
        REG_SEPARATION_BAND: separation_band <= cfg_data[14:0];
        REG_WINDUP_BOUND:    windup_bound    <= cfg_data[29:0];
        REG_LIMIT_ENABLE:    limit_enable    <= cfg_data[0];
        REG_LIMIT_UPPER:     limit_upper     <= cfg_data[31:0];
        REG_LIMIT_LOWER:     limit_lower     <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  logic s1_valid;
  logic s2_valid;
  logic out_free;
  logic s2_free;
  logic s1_free;
  logic take;

  assign out_free = !out_valid || out_ready;
  assign s2_free  = !s2_valid || out_free;
  assign s1_free  = !s1_valid || s2_free;
  assign in_ready = s1_free;
  assign take     = in_valid && in_ready;

  // stage 1: integrator update
  integ_res_t ires;

  pidsep_integ u_integ (
    .clk   (clk),
    .rst   (rst),
    .take  (take),
    .item  (in_data),
    .band  (separation_band),
    .bound (windup_bound),
    .res   (ires)
  );

  logic               s1_clr;
  logic               s1_use;
  logic signed [31:0] s1_acc;
  logic signed [15:0] s1_err;
  logic signed [15:0] s1_der;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_clr <= (in_data.kind == KIND_CLEAR);
      s1_use <= ires.use_i;
      s1_acc <= ires.acc;
      s1_err <= in_data.error_in;
      s1_der <= in_data.deriv_in;
    end
  end

  // stage 2: gain multiplies
  logic signed [31:0] pp_c;
  logic signed [31:0] pd_c;
  logic signed [47:0] pi_c;

  assign pp_c = 32'(gain_prop) * 32'(s1_err);
  assign pd_c = 32'(gain_deriv) * 32'(s1_der);
  assign pi_c = 48'(gain_integ) * 48'(s1_acc);

  logic               s2_clr;
  logic               s2_use;
  logic signed [31:0] s2_pp;
  logic signed [31:0] s2_pd;
  logic signed [47:0] s2_pi;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && s1_valid) begin
      s2_clr <= s1_clr;
      s2_use <= s1_use;
      s2_pp  <= pp_c;
      s2_pd  <= pd_c;
      s2_pi  <= s1_use ? pi_c : 48'sd0;
    end
  end

  // stage 3: sum, floor shift, saturate, clamp
  logic signed [49:0] sum_c;
  logic signed [41:0] sh_c;
  logic signed [31:0] sat_c;
  logic signed [31:0] drive_c;
  out_item_t          out_next;

  always_comb begin
    sum_c = {{18{s2_pp[31]}}, s2_pp} + {{18{s2_pd[31]}}, s2_pd} + {{2{s2_pi[47]}}, s2_pi};
    // dropping the low bits of two's complement rounds toward minus infinity
    sh_c  = sum_c[49:8];
    if (sh_c[41:31] != {11{sh_c[41]}}) begin
      sat_c = sh_c[41] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      sat_c = sh_c[31:0];
    end

    drive_c = sat_c;
    if (limit_enable) begin
      // upper test wins when the limits cross
      if (sat_c > limit_upper) begin
        drive_c = limit_upper;
      end else if (sat_c < limit_lower) begin
        drive_c = limit_lower;
      end
    end

    if (s2_clr) begin
      out_next.drive_out  = 32'sd0;
      out_next.integ_used = 1'b0;
    end else begin
      out_next.drive_out  = drive_c;
      out_next.integ_used = s2_use;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s2_valid) begin
      out_data <= out_next;
    end
  end

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the PID step block with integral separation and anti-windup.
`timescale 1ns / 1ps

module tb_top;
  import pidsep_pkg::*;

  localparam longint DRIVE_MAX = 64'sh7FFF_FFFF;
  localparam longint DRIVE_MIN = -64'sh8000_0000;
  localparam int     BOUND_MAX = 32'h3FFF_FFFF;
  localparam int     BAND_MAX  = 32767;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b1;
  out_item_t             out_data;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // shadow of the register file and the integrator
  logic signed [15:0] gain_prop_r;
  logic signed [15:0] gain_integ_r;
  logic signed [15:0] gain_deriv_r;
  logic [14:0]        band_r;
  logic [29:0]        bound_r;
  logic               limit_en_r;
  logic signed [31:0] limit_up_r;
  logic signed [31:0] limit_lo_r;
  logic signed [31:0] integ_acc_m;

  out_item_t drive_expect_q[$];
  int        mismatch_count = 0;
  logic      idle_on = 1'b1;
  int        stall_left = 0;

  pid_integral_separation_antiwindup DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 40) $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  function automatic longint clip32(input longint v);
    if (v > DRIVE_MAX) return DRIVE_MAX;
    if (v < DRIVE_MIN) return DRIVE_MIN;
    return v;
  endfunction

  function automatic out_item_t pid_predict(input in_item_t it);
    longint   err, der, band, bound, acc, sum, res;
    logic     use_i;
    out_item_t r;
    r = '0;
    if (it.kind == KIND_CLEAR) begin
      integ_acc_m = '0;
      return r;
    end
    err = $signed(it.error_in);
    der = $signed(it.deriv_in);
    band = longint'(band_r);
    bound = longint'(bound_r);
    use_i = (err <= band) && (err >= -band);
    if (use_i) begin
      acc = longint'(integ_acc_m);
      // past either bound only error of the opposite sign gets in
      if (acc > bound) begin
        if (err < 0) acc += err;
      end else if (acc < -bound) begin
        if (err > 0) acc += err;
      end else begin
        acc += err;
      end
      integ_acc_m = 32'(clip32(acc));
    end
    sum = longint'(gain_prop_r) * err + longint'(gain_deriv_r) * der;
    if (use_i) sum += longint'(gain_integ_r) * longint'(integ_acc_m);
    res = clip32(sum >>> 8);
    if (limit_en_r) begin
      if (res > limit_up_r) res = limit_up_r;
      else if (res < limit_lo_r) res = limit_lo_r;
    end
    r.drive_out = res[31:0];
    r.integ_used = use_i;
    return r;
  endfunction

  // called at a falling edge with the block idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    case (idx)
      REG_GAIN_PROP:       gain_prop_r = val[15:0];
      REG_GAIN_INTEG:      gain_integ_r = val[15:0];
      REG_GAIN_DERIV:      gain_deriv_r = val[15:0];
      REG_SEPARATION_BAND: band_r = val[14:0];
      REG_WINDUP_BOUND:    bound_r = val[29:0];
      REG_LIMIT_ENABLE:    limit_en_r = val[0];
      REG_LIMIT_UPPER:     limit_up_r = val;
      REG_LIMIT_LOWER:     limit_lo_r = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic load_settings(input int gp, input int gi, input int gd, input int band,
                               input int bound, input int en, input int up, input int lo);
    write_reg(REG_GAIN_PROP, gp);
    write_reg(REG_GAIN_INTEG, gi);
    write_reg(REG_GAIN_DERIV, gd);
    write_reg(REG_SEPARATION_BAND, band);
    write_reg(REG_WINDUP_BOUND, bound);
    write_reg(REG_LIMIT_ENABLE, en);
    write_reg(REG_LIMIT_UPPER, up);
    write_reg(REG_LIMIT_LOWER, lo);
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (drive_expect_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // entered at a falling edge; returns at the falling edge after acceptance with valid high
  task automatic send_item(input logic kind, input logic signed [15:0] err,
                           input logic signed [15:0] der);
    in_item_t it;
    it.kind = kind;
    it.error_in = err;
    it.deriv_in = der;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = it;
    do @(posedge clk); while (!in_ready);
    drive_expect_q.push_back(pid_predict(it));
    @(negedge clk);
  endtask

  function automatic int pick_gain();
    logic signed [15:0] g;
    g = 16'($urandom);
    case ($urandom_range(0, 5))
      0: g = 16'sh8000;
      1: g = 16'sh7FFF;
      2: g = '0;
      default: ;
    endcase
    return g;
  endfunction

  function automatic int pick_limit();
    case ($urandom_range(0, 4))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_defaults();
    send_item(KIND_STEP, 16'sh7FFF, 16'sh8000);
    // most negative error lies outside the widest band
    send_item(KIND_STEP, 16'sh8000, 16'sh7FFF);
    send_item(KIND_STEP, 16'sh0000, 16'sh0000);
    send_item(KIND_CLEAR, 16'sh1234, 16'shFFFF);
  endtask

  task automatic test_separation_band();
    wait_idle();
    load_settings(256, 256, 256, 1000, int'(RST_WINDUP_BOUND), 0, RST_LIMIT_UPPER,
                  RST_LIMIT_LOWER);
    send_item(KIND_STEP, 1000, 1);
    send_item(KIND_STEP, -1000, -1);
    send_item(KIND_STEP, 1001, 0);
    send_item(KIND_STEP, -1001, 0);
    wait_idle();
    write_reg(REG_SEPARATION_BAND, 0);
    send_item(KIND_STEP, 0, 5);
    send_item(KIND_STEP, 1, 5);
  endtask

  task automatic test_windup_bound();
    wait_idle();
    load_settings(0, 256, 0, BAND_MAX, 100, 0, RST_LIMIT_UPPER, RST_LIMIT_LOWER);
    send_item(KIND_CLEAR, 0, 0);
    send_item(KIND_STEP, 60, 0);
    send_item(KIND_STEP, 40, 0);    // lands on the bound
    send_item(KIND_STEP, 50, 0);    // on the bound still accepts
    send_item(KIND_STEP, 20, 0);    // above the bound, rejected
    send_item(KIND_STEP, -10, 0);
    send_item(KIND_CLEAR, 0, 0);
    send_item(KIND_STEP, -100, 0);
    send_item(KIND_STEP, -1, 0);
    send_item(KIND_STEP, -5, 0);
    send_item(KIND_STEP, 7, 0);
  endtask

  task automatic test_output_clamp();
    wait_idle();
    load_settings(256, 0, 0, BAND_MAX, int'(RST_WINDUP_BOUND), 1, 100, -100);
    send_item(KIND_STEP, 500, 0);
    send_item(KIND_STEP, -500, 0);
    send_item(KIND_STEP, 50, 0);
    wait_idle();
    // crossed limits: upper wins when both apply
    write_reg(REG_LIMIT_UPPER, -50);
    write_reg(REG_LIMIT_LOWER, 50);
    send_item(KIND_STEP, 0, 0);
    send_item(KIND_STEP, -100, 0);
  endtask

  // small bands and bounds so separation and windup trip often
  task automatic test_random_mix();
    int band, bound, err;
    for (int ph = 0; ph < 3; ph++) begin
      wait_idle();
      case ($urandom_range(0, 3))
        0: band = ($urandom_range(0, 1) != 0) ? 0 : BAND_MAX;
        default: band = $urandom_range(0, 4000);
      endcase
      case ($urandom_range(0, 4))
        0: bound = 0;
        1: bound = BOUND_MAX;
        default: bound = $urandom_range(0, 20000);
      endcase
      load_settings(pick_gain(), pick_gain(), pick_gain(), band, bound,
                    $urandom_range(0, 1), pick_limit(), pick_limit());
      for (int i = 0; i < 25; i++) begin
        if ($urandom_range(0, 99) < 8) begin
          send_item(KIND_CLEAR, 16'($urandom), 16'($urandom));
        end else begin
          if ($urandom_range(0, 9) < 7) err = int'($urandom_range(0, 2 * band)) - band;
          else err = 16'($urandom);
          send_item(KIND_STEP, 16'(err), 16'($urandom));
        end
      end
    end
  endtask

  // drive the integrator far enough that the gain product saturates the output
  task automatic test_integral_ramp();
    for (int ch = 0; ch < 4; ch++) begin
      wait_idle();
      load_settings(pick_gain(), 32767, pick_gain(), BAND_MAX, BOUND_MAX,
                    $urandom_range(0, 1), pick_limit(), pick_limit());
      if (ch == 0) send_item(KIND_CLEAR, 0, 0);
      for (int i = 0; i < 150; i++) begin
        if (ch == 1 && i == 75) wait_idle();
        if ($urandom_range(0, 99) < 5) send_item(KIND_STEP, 16'($urandom), 16'($urandom));
        else send_item(KIND_STEP, 16'($urandom_range(31500, 32767)), 16'($urandom));
      end
    end
  endtask

  task automatic test_negative_drive();
    wait_idle();
    idle_on = 1'b0;
    load_settings(pick_gain(), -32768, pick_gain(), BAND_MAX, BOUND_MAX, 0,
                  RST_LIMIT_UPPER, RST_LIMIT_LOWER);
    for (int i = 0; i < 60; i++) send_item(KIND_STEP, 16'($urandom), 16'($urandom));
    send_item(KIND_CLEAR, 16'($urandom), 16'($urandom));
  endtask

  // receiver stalls in short bursts
  always @(negedge clk) begin
    if (idle_on && stall_left == 0 && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 3);
    if (!idle_on) stall_left = 0;
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (drive_expect_q.size() == 0) begin
        report_mismatch($sformatf("result with none pending, drive_out %0d", out_data.drive_out));
      end else begin
        want = drive_expect_q.pop_front();
        if (out_data.drive_out !== want.drive_out)
          report_mismatch($sformatf("drive_out %0d, expected %0d",
                                    out_data.drive_out, want.drive_out));
        if (out_data.integ_used !== want.integ_used)
          report_mismatch($sformatf("integ_used %0b, expected %0b",
                                    out_data.integ_used, want.integ_used));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    gain_prop_r = RST_GAIN_PROP;
    gain_integ_r = RST_GAIN_INTEG;
    gain_deriv_r = RST_GAIN_DERIV;
    band_r = RST_SEPARATION_BAND;
    bound_r = RST_WINDUP_BOUND;
    limit_en_r = RST_LIMIT_ENABLE;
    limit_up_r = RST_LIMIT_UPPER;
    limit_lo_r = RST_LIMIT_LOWER;
    integ_acc_m = '0;
    repeat (12) @(negedge clk);
    rst = 1'b0;
    test_defaults();
    test_separation_band();
    test_windup_bound();
    test_output_clamp();
    test_random_mix();
    test_integral_ramp();
    test_negative_drive();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[sim.f]
design/pidsep_pkg.sv
design/pidsep_integ.sv
design/pid_integral_separation_antiwindup.sv
tb/tb_top.sv
